FILE: sv/brcs_pkg.sv
// Package for the best root candidate selector.
// Holds the request and result types and the position constants; no dependencies.
`default_nettype none

package brcs_pkg;

  // Largest set size the position counter is meant for.
  localparam int MAX_CANDIDATES = 64;
  localparam int POS_W          = 6;
  localparam int POS_TOP_INT    = (MAX_CANDIDATES - 1) < 63 ? (MAX_CANDIDATES - 1) : 63;
  localparam logic [POS_W-1:0] POS_TOP = POS_W'(POS_TOP_INT);

  localparam int SCORE_W = 14;

  typedef struct packed {
    logic [2:0]         preference;
    logic [7:0]         stratum_level;
    logic signed [11:0] rssi_avg;
    logic signed [11:0] snr_avg;
    logic [63:0]        candidate_eui;
    logic               sig_ok;
    logic               last_candidate;
  } brcs_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] winner_index;
    logic [63:0]      winner_eui;
  } brcs_out_t;

endpackage

`default_nettype wire

FILE: sv/best_root_candidate_select.sv
// Top level of the best root candidate selector.
// Depends on brcs_pkg for the request and result types and position constants.
`default_nettype none

// Streams root candidates, one request per clock, and keeps the best one of the
// current set: higher preference first, then lower stratum, then higher link
// score 2*rssi_avg + snr_avg (exact, 1/16 dB steps), then the smaller
// identifier; on a full tie the earlier candidate stays. Candidates with
// sig_ok low are skipped but still use up a position. A request with
// last_candidate high closes the set: it is ranked like any other, then one
// result (found, winner_index, winner_eui) is issued and the state clears for
// the next set. Positions count from 0 and stop at POS_TOP. Each request goes
// through an input register and is then ranked against the stored best by
// one compare; the result register follows, so a result is valid in the
// cycle after its closing request is ranked. Throughput is one request per
// cycle; the input side stalls only while a closing request waits for the
// result register, which is held by a stalled earlier result.
module best_root_candidate_select (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  brcs_pkg::brcs_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output brcs_pkg::brcs_out_t  out_data
);
  import brcs_pkg::*;

  // Input register
  logic     stg_valid_r;
  brcs_in_t stg_r;

  // Running best of the current set
  logic                      have_best_r;
  logic [2:0]                best_pref_r;
  logic [7:0]                best_stratum_r;
  logic signed [SCORE_W-1:0] best_score_r;
  logic [63:0]               best_id_r;
  logic [POS_W-1:0]          best_pos_r;
  logic [POS_W-1:0]          item_pos_r;

  // Result register
  logic      out_valid_r;
  brcs_out_t out_r;

  logic                      out_free;
  logic                      advance;
  logic                      in_accept;
  logic signed [SCORE_W-1:0] score;
  logic                      better;
  logic                      take;
  brcs_out_t                 res_nxt;

  // Result slot opens when empty or when its result leaves this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  // Hold a closing request in the input register until the slot is free.
  assign advance   = stg_valid_r && (!stg_r.last_candidate || out_free);
  assign in_stall  = stg_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // Link score: sign-extend both averages to score width, RSSI doubled.
  assign score = {stg_r.rssi_avg[11], stg_r.rssi_avg, 1'b0}
               + {{2{stg_r.snr_avg[11]}}, stg_r.snr_avg};

  always_comb begin
    if (stg_r.preference != best_pref_r) begin
      better = stg_r.preference > best_pref_r;
    end else if (stg_r.stratum_level != best_stratum_r) begin
      better = stg_r.stratum_level < best_stratum_r;
    end else if (score != best_score_r) begin
      better = score > best_score_r;
    end else begin
      better = stg_r.candidate_eui < best_id_r;
    end
  end

  assign take = stg_r.sig_ok && (!have_best_r || better);

  // Result of a closing request reflects the best after ranking that request.
  always_comb begin
    res_nxt.found = have_best_r || take;
    if (take) begin
      res_nxt.winner_index = item_pos_r;
      res_nxt.winner_eui   = stg_r.candidate_eui;
    end else if (have_best_r) begin
      res_nxt.winner_index = best_pos_r;
      res_nxt.winner_eui   = best_id_r;
    end else begin
      res_nxt.winner_index = '0;
      res_nxt.winner_eui   = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      have_best_r <= 1'b0;
      item_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        stg_valid_r <= 1'b1;
      end else if (advance) begin
        stg_valid_r <= 1'b0;
      end

      if (advance) begin
        if (stg_r.last_candidate) begin
          // Close the set: drop the kept best and restart positions.
          have_best_r <= 1'b0;
          item_pos_r  <= '0;
        end else begin
          if (take) begin
            have_best_r <= 1'b1;
          end
          if (item_pos_r < POS_TOP) begin
            item_pos_r <= item_pos_r + POS_W'(1);
          end
        end
      end

      if (advance && stg_r.last_candidate) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_r <= in_data;
    end
    if (advance && take) begin
      best_pref_r    <= stg_r.preference;
      best_stratum_r <= stg_r.stratum_level;
      best_score_r   <= score;
      best_id_r      <= stg_r.candidate_eui;
      best_pos_r     <= item_pos_r;
    end
    if (advance && stg_r.last_candidate) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result without a winner carries zero index and identifier.
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.winner_index == '0 && out_r.winner_eui == '0))
    else $error("empty result carries nonzero winner fields");

  // Position counter never passes its top value.
  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    item_pos_r <= POS_TOP)
    else $error("item position beyond top");

  // A closing request clears the set state on the next cycle.
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg_r.last_candidate) |=> (!have_best_r && item_pos_r == '0 && out_valid_r))
    else $error("set state not cleared after closing request");

  // Input stalls only behind a closing request that cannot reach the result slot.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stg_valid_r && stg_r.last_candidate && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

FILE: tb/sv/brcs_winner_checker.sv
// Scoreboard for the best root candidate selector: watches both channels,
// ranks every accepted request and compares each result with the predicted winner.
// Depends on brcs_pkg for the request and result types and POS_TOP.

module brcs_winner_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  brcs_pkg::brcs_in_t   in_data,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  brcs_pkg::brcs_out_t  out_data,
  output int                   fail_count,
  output int                   pending_count
);

  // Best candidate of the open set, as the block should hold it.
  logic                          kept_valid   = 1'b0;
  logic [2:0]                    kept_pref    = '0;
  logic [7:0]                    kept_stratum = '0;
  logic signed [13:0]            kept_score   = '0;
  logic [63:0]                   kept_eui     = '0;
  logic [brcs_pkg::POS_W-1:0]    kept_pos     = '0;
  logic [brcs_pkg::POS_W-1:0]    next_pos     = '0;

  brcs_pkg::brcs_out_t winners_due[$];
  brcs_pkg::brcs_out_t oldest;
  int                  fails = 0;

  function automatic logic outranks(input logic [2:0] pref, input logic [7:0] strat,
                                    input logic signed [13:0] score, input logic [63:0] eui);
    if (pref != kept_pref) return pref > kept_pref;
    if (strat != kept_stratum) return strat < kept_stratum;
    if (score != kept_score) return score > kept_score;
    return eui < kept_eui;
  endfunction

  task automatic clear_set();
    kept_valid   = 1'b0;
    kept_pref    = '0;
    kept_stratum = '0;
    kept_score   = '0;
    kept_eui     = '0;
    kept_pos     = '0;
    next_pos     = '0;
  endtask

  task automatic rank_candidate(input brcs_pkg::brcs_in_t c);
    logic signed [13:0]  score;
    brcs_pkg::brcs_out_t w;
    // operands widen to 14 bits before the shift, so the score is exact
    score = ($signed(c.rssi_avg) <<< 1) + $signed(c.snr_avg);
    if (c.sig_ok && (!kept_valid || outranks(c.preference, c.stratum_level, score,
                                            c.candidate_eui))) begin
      kept_valid   = 1'b1;
      kept_pref    = c.preference;
      kept_stratum = c.stratum_level;
      kept_score   = score;
      kept_eui     = c.candidate_eui;
      kept_pos     = next_pos;
    end
    // position sticks at its top value in long sets
    if (next_pos < brcs_pkg::POS_TOP) next_pos = next_pos + 1'b1;
    if (c.last_candidate) begin
      w.found        = kept_valid;
      w.winner_index = kept_valid ? kept_pos : '0;
      w.winner_eui   = kept_valid ? kept_eui : '0;
      winners_due.push_back(w);
      clear_set();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_set();
    end else begin
      if (out_valid && !out_stall) begin
        if (winners_due.size() == 0) begin
          $error("result with no closed set pending: found %0d index %0d eui %h",
                 out_data.found, out_data.winner_index, out_data.winner_eui);
          fails++;
        end else begin
          oldest = winners_due.pop_front();
          if (out_data.found !== oldest.found) begin
            $error("found: expected %0d, got %0d", oldest.found, out_data.found);
            fails++;
          end
          if (out_data.winner_index !== oldest.winner_index) begin
            $error("winner_index: expected %0d, got %0d",
                   oldest.winner_index, out_data.winner_index);
            fails++;
          end
          if (out_data.winner_eui !== oldest.winner_eui) begin
            $error("winner_eui: expected %h, got %h", oldest.winner_eui, out_data.winner_eui);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) rank_candidate(in_data);
    end
    fail_count    <= fails;
    pending_count <= winners_due.size();
  end

endmodule

FILE: tb/sv/best_root_candidate_select_test.sv
// Top of the best root candidate selector testbench: clock, reset, request
// stimulus, result-side stall and the verdict. Depends on brcs_pkg,
// best_root_candidate_select and brcs_winner_checker.

module best_root_candidate_select_test;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  brcs_pkg::brcs_in_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  brcs_pkg::brcs_out_t out_data;

  int fail_count;
  int pending_count;

  // Shared switch for random idling on both sides; cleared for a long clean stretch.
  bit gaps_on = 1'b1;

  best_root_candidate_select u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  brcs_winner_checker u_winner_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up long after the slowest legal run would have finished.
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Stall the result side about a third of the time while gaps are enabled.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 33);
  end

  // Present one request and hold it until accepted. Idle cycles go in front
  // of the request so valid never drops while a request is waiting.
  task automatic send_request(input brcs_pkg::brcs_in_t req);
    while (gaps_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    // in_stall read here is the value the block saw at this edge
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every closed set has reported its winner.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic brcs_pkg::brcs_in_t build_candidate(
      input int pref, input int strat, input int rssi, input int snr,
      input logic [63:0] eui, input bit sig, input bit is_last);
    brcs_pkg::brcs_in_t c;
    c.preference     = 3'(pref);
    c.stratum_level  = 8'(strat);
    c.rssi_avg       = 12'(rssi);
    c.snr_avg        = 12'(snr);
    c.candidate_eui  = eui;
    c.sig_ok         = sig;
    c.last_candidate = is_last;
    return c;
  endfunction

  // Take each field from the set's base half the time so ties on the
  // leading keys are common and the later keys get exercised.
  function automatic brcs_pkg::brcs_in_t vary_candidate(input brcs_pkg::brcs_in_t base,
                                                       input int sig_pct);
    brcs_pkg::brcs_in_t c;
    c = base;
    if ($urandom_range(1)) c.preference    = 3'($urandom);
    if ($urandom_range(1)) c.stratum_level = 8'($urandom);
    if ($urandom_range(1)) c.rssi_avg      = 12'($urandom);
    if ($urandom_range(1)) c.snr_avg       = 12'($urandom);
    case ($urandom_range(3))
      0: c.candidate_eui = {$urandom, $urandom};
      1: c.candidate_eui = 64'($urandom_range(3));
      default: ;
    endcase
    c.sig_ok = $urandom_range(99) < sig_pct;
    return c;
  endfunction

  localparam int RANDOM_REQUESTS = 1800;

  initial begin
    brcs_pkg::brcs_in_t base;
    brcs_pkg::brcs_in_t cand;
    int  sent;
    int  set_len;
    int  sig_pct;
    bit  long_set;
    bit  drained;

    sent    = 0;
    drained = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets.
    // unsigned set of one: nothing found
    send_request(build_candidate(7, 0, 2047, 2047, '1, 1'b0, 1'b1));
    // signed set of one with the best preference, stratum and scores and the largest eui
    send_request(build_candidate(7, 0, 2047, 2047, '1, 1'b1, 1'b1));
    // signed set of one with the worst preference, stratum and scores: found with eui zero
    send_request(build_candidate(0, 255, -2048, -2048, '0, 1'b1, 1'b1));
    // preference beats everything below it
    send_request(build_candidate(3, 10, 2047, 2047, 64'd5, 1'b1, 1'b0));
    send_request(build_candidate(4, 200, -2048, -2048, '1, 1'b1, 1'b1));
    // lower stratum wins at equal preference
    send_request(build_candidate(2, 50, 100, 100, 64'd9, 1'b1, 1'b0));
    send_request(build_candidate(2, 49, -100, -100, 64'd10, 1'b1, 1'b0));
    send_request(build_candidate(2, 255, 2047, 2047, 64'd0, 1'b1, 1'b1));
    // score, then eui, then exact tie keeps the earlier one;
    // an unsigned candidate that would win is skipped
    send_request(build_candidate(1, 7, 10, 0, 64'd1, 1'b1, 1'b0));
    send_request(build_candidate(1, 7, 0, 21, 64'd2, 1'b1, 1'b0));
    send_request(build_candidate(1, 7, 5, 11, 64'd0, 1'b1, 1'b0));
    send_request(build_candidate(1, 7, 5, 11, 64'd0, 1'b1, 1'b0));
    send_request(build_candidate(7, 0, 2047, 2047, 64'd0, 1'b0, 1'b1));
    // negative scores compare as signed
    send_request(build_candidate(5, 5, -2048, 2047, 64'd3, 1'b1, 1'b0));
    send_request(build_candidate(5, 5, -1, -2048, 64'd4, 1'b1, 1'b1));
    // all unsigned, two items
    send_request(build_candidate(6, 1, 0, 0, 64'd1, 1'b0, 1'b0));
    send_request(build_candidate(6, 1, 0, 0, 64'd1, 1'b0, 1'b1));

    // Random sets: mostly short, a few past the position limit.
    while (sent < RANDOM_REQUESTS) begin
      gaps_on = !(sent >= 600 && sent < 1000);
      if (!drained && sent >= 1200) begin
        drain_results();
        drained = 1'b1;
      end
      long_set = $urandom_range(19) == 0;
      set_len  = long_set ? $urandom_range(90, 60) : $urandom_range(12, 1);
      case ($urandom_range(9))
        0:       sig_pct = 0;
        1, 2:    sig_pct = 50;
        default: sig_pct = 90;
      endcase
      base.preference    = long_set ? 3'($urandom_range(5)) : 3'($urandom);
      base.stratum_level = 8'($urandom);
      base.rssi_avg      = 12'($urandom);
      base.snr_avg       = 12'($urandom);
      base.candidate_eui = {$urandom, $urandom};
      base.sig_ok        = 1'b1;
      base.last_candidate = 1'b0;
      for (int k = 0; k < set_len; k++) begin
        cand = vary_candidate(base, sig_pct);
        // push late winners into long sets so the clamped position shows up
        if (long_set && k >= 62 && $urandom_range(3) == 0) begin
          cand.preference    = 3'd7;
          cand.stratum_level = 8'd0;
          cand.sig_ok        = 1'b1;
        end
        cand.last_candidate = (k == set_len - 1);
        send_request(cand);
        sent++;
      end
    end

    gaps_on = 1'b1;
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
